/* src/dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue and its storage.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 6;

  typedef enum logic [OpW-1:0] {
    DQ_PUSH_FRONT = 3'd0,
    DQ_PUSH_BACK  = 3'd1,
    DQ_POP_FRONT  = 3'd2,
    DQ_POP_BACK   = 3'd3,
    DQ_CLEAR      = 3'd4,
    DQ_DUMP       = 3'd5
  } dq_op_e;

  typedef enum logic [StatusW-1:0] {
    DQ_OK    = 2'd0,
    DQ_EMPTY = 2'd1,
    DQ_FULL  = 2'd2
  } dq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } dq_state_e;

  typedef struct packed {
    dq_op_e                    opcode;
    logic signed [DataW-1:0]   data_value;
  } dq_req_t;

  typedef struct packed {
    logic signed [DataW-1:0]   out_value;
    dq_status_e                status;
    logic        [CountW-1:0]  entry_count;
    logic                      last_result;
  } dq_rsp_t;

endpackage

`default_nettype wire

/* src/dq_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_mem
// Entry storage: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  wire logic signed [dq_pkg::DataW-1:0]     wdata_i,
  input  wire logic                                re_i,
  input  wire logic [$clog2(DEPTH)-1:0]            raddr_i,
  output      logic signed [dq_pkg::DataW-1:0]     rdata_o
);

  logic signed [dq_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [dq_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a circular RAM.
//
// Requests arrive on in_valid_i/in_ready_o with an opcode and a value;
// results leave on out_valid_o/out_ready_i through a single output register.
// Push, clear, a push to a full queue and a pop or dump of an empty queue
// give their result in the cycle after acceptance. A pop reads the RAM into
// its read register, which then loads the output register. A dump of N
// entries streams one entry per cycle from the RAM read port while the
// receiver accepts, and holds off new requests until the last one is
// delivered. Undefined opcodes are accepted and dropped without a result.
// A new request is taken in the idle state whenever the output register is
// empty or being drained, so back-to-back pushes run at one per cycle while
// the receiver accepts, and a pop holds off the next request until its result
// is loaded; the RAM read port sets the pop and dump pace. When the receiver
// stalls, the result holds and input stalls behind it. Reset empties the queue
// and the output register; RAM contents stay undefined; only live entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire dq_pkg::dq_req_t in_req_i,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      dq_pkg::dq_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  function automatic logic [IdxW-1:0] wrap_idx(input logic [SumW-1:0] s);
    logic [SumW-1:0] r;
    r = (s >= SumW'(DEPTH)) ? (s - SumW'(DEPTH)) : s;
    return r[IdxW-1:0];
  endfunction

  dq_pkg::dq_state_e state_q, state_d;
  logic [IdxW-1:0]   front_q, front_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic [CntW-1:0]   deliver_q, deliver_d;
  logic              pending_q, pending_d;
  logic              out_valid_q, out_valid_d;
  dq_pkg::dq_rsp_t   out_rsp_q, out_rsp_d;

  logic                            mem_we;
  logic [IdxW-1:0]                 mem_waddr;
  logic                            mem_re;
  logic [IdxW-1:0]                 mem_raddr;
  logic signed [dq_pkg::DataW-1:0] mem_rdata;

  logic            out_free;
  logic            accept;
  logic            full;
  logic            empty;
  logic            take;
  logic            last;
  logic [IdxW-1:0] front_dec;
  logic [IdxW-1:0] front_inc;

  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - IdxW'(1);
  assign front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + IdxW'(1);
  assign take      = pending_q && out_free;
  assign last      = (deliver_q == count_q - CntW'(1));

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    issue_d     = issue_q;
    deliver_d   = deliver_q;
    pending_d   = pending_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = front_q;
    mem_re      = 1'b0;
    mem_raddr   = front_q;

    unique case (state_q)
      dq_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          unique case (in_req_i.opcode)
            dq_pkg::DQ_PUSH_FRONT, dq_pkg::DQ_PUSH_BACK: begin
              out_valid_d           = 1'b1;
              out_rsp_d.out_value   = '0;
              out_rsp_d.last_result = 1'b1;
              if (full) begin
                out_rsp_d.status      = dq_pkg::DQ_FULL;
                out_rsp_d.entry_count = dq_pkg::CountW'(count_q);
              end else begin
                mem_we = 1'b1;
                if (in_req_i.opcode == dq_pkg::DQ_PUSH_FRONT) begin
                  mem_waddr = front_dec;
                  front_d   = front_dec;
                end else begin
                  mem_waddr = wrap_idx(SumW'(front_q) + SumW'(count_q));
                end
                count_d               = count_q + CntW'(1);
                out_rsp_d.status      = dq_pkg::DQ_OK;
                out_rsp_d.entry_count = dq_pkg::CountW'(count_q + CntW'(1));
              end
            end
            dq_pkg::DQ_POP_FRONT, dq_pkg::DQ_POP_BACK, dq_pkg::DQ_DUMP: begin
              if (empty) begin
                out_valid_d           = 1'b1;
                out_rsp_d.out_value   = '0;
                out_rsp_d.status      = dq_pkg::DQ_EMPTY;
                out_rsp_d.entry_count = '0;
                out_rsp_d.last_result = 1'b1;
              end else begin
                mem_re    = 1'b1;
                pending_d = 1'b1;
                if (in_req_i.opcode == dq_pkg::DQ_DUMP) begin
                  mem_raddr = front_q;
                  issue_d   = CntW'(1);
                  deliver_d = '0;
                  state_d   = dq_pkg::ST_DUMP;
                end else begin
                  if (in_req_i.opcode == dq_pkg::DQ_POP_FRONT) begin
                    mem_raddr = front_q;
                    front_d   = front_inc;
                  end else begin
                    mem_raddr = wrap_idx(SumW'(front_q) + SumW'(count_q - CntW'(1)));
                  end
                  count_d = count_q - CntW'(1);
                  state_d = dq_pkg::ST_POP;
                end
              end
            end
            dq_pkg::DQ_CLEAR: begin
              count_d               = '0;
              out_valid_d           = 1'b1;
              out_rsp_d.out_value   = '0;
              out_rsp_d.status      = dq_pkg::DQ_OK;
              out_rsp_d.entry_count = '0;
              out_rsp_d.last_result = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      dq_pkg::ST_POP: begin
        if (take) begin
          out_valid_d           = 1'b1;
          out_rsp_d.out_value   = mem_rdata;
          out_rsp_d.status      = dq_pkg::DQ_OK;
          out_rsp_d.entry_count = dq_pkg::CountW'(count_q);
          out_rsp_d.last_result = 1'b1;
          pending_d             = 1'b0;
          state_d               = dq_pkg::ST_IDLE;
        end
      end

      dq_pkg::ST_DUMP: begin
        if (take) begin
          out_valid_d           = 1'b1;
          out_rsp_d.out_value   = mem_rdata;
          out_rsp_d.status      = dq_pkg::DQ_OK;
          out_rsp_d.entry_count = dq_pkg::CountW'(count_q);
          out_rsp_d.last_result = last;
          deliver_d             = deliver_q + CntW'(1);
          pending_d             = 1'b0;
          if (last) begin
            state_d = dq_pkg::ST_IDLE;
          end
        end
        if ((issue_q < count_q) && (!pending_q || take)) begin
          mem_re    = 1'b1;
          mem_raddr = wrap_idx(SumW'(front_q) + SumW'(issue_q));
          issue_d   = issue_q + CntW'(1);
          pending_d = 1'b1;
        end
      end

      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      issue_q     <= '0;
      deliver_q   <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      deliver_q   <= deliver_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  dq_mem #(
    .DEPTH (DEPTH)
  ) u_dq_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_req_i.data_value),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

/* dv/double_ended_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque. Requests go in through the
// valid/ready input channel. A predictor keeps its own copy of the
// circular store and works out the result of each accepted request. The
// checker compares every delivered result with the oldest prediction.
// The directed cases cover the empty, full and wrap-around corners and
// clear. The random cases mix operations with idle gaps on both sides and
// a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_tb;

  localparam int unsigned QDepth     = 32;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned FlushWait  = 20;
  localparam logic [dq_pkg::OpW-1:0] OpRsvdLo = 3'd6;
  localparam logic [dq_pkg::OpW-1:0] OpRsvdHi = 3'd7;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  dq_pkg::dq_req_t in_req_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  dq_pkg::dq_rsp_t out_rsp_o;

  logic signed [dq_pkg::DataW-1:0] model_slot [QDepth];
  int unsigned     model_front = 0;
  int unsigned     model_count = 0;
  dq_pkg::dq_rsp_t pending_rsp [$];
  int unsigned     err_count   = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     rx_hold_len = 0;
  bit              src_idle_on = 1'b1;
  bit              snk_idle_on = 1'b1;

  double_ended_queue #(
    .DEPTH(QDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [dq_pkg::DataW-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [dq_pkg::OpW-1:0] rand_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::DQ_PUSH_BACK : dq_pkg::DQ_PUSH_FRONT;
    end
    if (r < 92) return $urandom_range(0, 1) ? dq_pkg::DQ_POP_BACK : dq_pkg::DQ_POP_FRONT;
    if (r < 96) return dq_pkg::DQ_DUMP;
    if (r < 98) return dq_pkg::DQ_CLEAR;
    return $urandom_range(0, 1) ? OpRsvdHi : OpRsvdLo;
  endfunction

  function automatic void add_rsp(logic signed [dq_pkg::DataW-1:0] value,
                                  dq_pkg::dq_status_e status, logic last);
    dq_pkg::dq_rsp_t rsp;
    rsp.out_value   = value;
    rsp.status      = status;
    rsp.entry_count = model_count[dq_pkg::CountW-1:0];
    rsp.last_result = last;
    pending_rsp.push_back(rsp);
  endfunction

  function automatic void deque_predict(dq_pkg::dq_req_t req);
    int unsigned pos;
    case (req.opcode)
      dq_pkg::DQ_PUSH_FRONT, dq_pkg::DQ_PUSH_BACK: begin
        if (model_count >= QDepth) begin
          add_rsp('0, dq_pkg::DQ_FULL, 1'b1);
        end else begin
          if (req.opcode == dq_pkg::DQ_PUSH_FRONT) begin
            model_front = (model_front + QDepth - 1) % QDepth;
            pos = model_front;
          end else begin
            pos = (model_front + model_count) % QDepth;
          end
          model_slot[pos] = req.data_value;
          model_count++;
          add_rsp('0, dq_pkg::DQ_OK, 1'b1);
        end
      end
      dq_pkg::DQ_POP_FRONT, dq_pkg::DQ_POP_BACK: begin
        if (model_count == 0) begin
          add_rsp('0, dq_pkg::DQ_EMPTY, 1'b1);
        end else begin
          if (req.opcode == dq_pkg::DQ_POP_FRONT) begin
            pos = model_front;
            model_front = (model_front + 1) % QDepth;
          end else begin
            pos = (model_front + model_count - 1) % QDepth;
          end
          model_count--;
          add_rsp(model_slot[pos], dq_pkg::DQ_OK, 1'b1);
        end
      end
      dq_pkg::DQ_CLEAR: begin
        model_count = 0;
        add_rsp('0, dq_pkg::DQ_OK, 1'b1);
      end
      dq_pkg::DQ_DUMP: begin
        if (model_count == 0) begin
          add_rsp('0, dq_pkg::DQ_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < model_count; i++) begin
            add_rsp(model_slot[(model_front + i) % QDepth], dq_pkg::DQ_OK,
                    i + 1 == model_count);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [dq_pkg::DataW-1:0] got,
                                 logic [dq_pkg::DataW-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
    err_count++;
  endtask

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(logic [dq_pkg::OpW-1:0] op,
                          logic signed [dq_pkg::DataW-1:0] value);
    int unsigned     gap;
    dq_pkg::dq_req_t req;
    gap = (src_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.opcode     = dq_pkg::dq_op_e'(op);
    req.data_value = value;
    in_req_i       = req;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deque_predict(req);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed_edges();
    send_req(dq_pkg::DQ_POP_FRONT, 32'h1234_5678);
    send_req(dq_pkg::DQ_POP_BACK, 32'h0);
    send_req(dq_pkg::DQ_DUMP, 32'hffff_ffff);
    send_req(dq_pkg::DQ_PUSH_FRONT, 32'h7fff_ffff);
    send_req(dq_pkg::DQ_PUSH_BACK, 32'h8000_0000);
    send_req(dq_pkg::DQ_PUSH_FRONT, 32'h0);
    send_req(dq_pkg::DQ_PUSH_BACK, 32'hffff_ffff);
    send_req(OpRsvdLo, 32'hdead_beef);
    send_req(OpRsvdHi, 32'h0bad_f00d);
    send_req(dq_pkg::DQ_DUMP, 32'h0);
    send_req(dq_pkg::DQ_POP_FRONT, 32'h0);
    send_req(dq_pkg::DQ_POP_BACK, 32'h0);
    send_req(dq_pkg::DQ_CLEAR, 32'h0);
    send_req(dq_pkg::DQ_DUMP, 32'h0);
    send_req(dq_pkg::DQ_POP_BACK, 32'h0);
    send_req(dq_pkg::DQ_PUSH_BACK, 32'h5555_5555);
    send_req(dq_pkg::DQ_PUSH_FRONT, 32'haaaa_aaaa);
    send_req(dq_pkg::DQ_DUMP, 32'h0);
    send_req(dq_pkg::DQ_POP_BACK, 32'h0);
    send_req(dq_pkg::DQ_POP_FRONT, 32'h0);
    send_req(dq_pkg::DQ_DUMP, 32'h0);
  endtask

  task automatic test_fill_and_drain();
    send_req(dq_pkg::DQ_CLEAR, rand_value());
    while (model_count < QDepth) begin
      send_req($urandom_range(0, 1) ? dq_pkg::DQ_PUSH_BACK : dq_pkg::DQ_PUSH_FRONT,
               rand_value());
    end
    send_req(dq_pkg::DQ_PUSH_FRONT, rand_value());
    send_req(dq_pkg::DQ_PUSH_BACK, rand_value());
    send_req(dq_pkg::DQ_DUMP, rand_value());
    while (model_count > 0) begin
      send_req($urandom_range(0, 1) ? dq_pkg::DQ_POP_BACK : dq_pkg::DQ_POP_FRONT,
               rand_value());
    end
    send_req(dq_pkg::DQ_POP_FRONT, rand_value());
  endtask

  task automatic test_backpressure();
    wait_drained();
    rx_hold_len = 200;
    repeat (20) begin
      send_req($urandom_range(0, 1) ? dq_pkg::DQ_PUSH_BACK : dq_pkg::DQ_PUSH_FRONT,
               rand_value());
    end
    send_req(dq_pkg::DQ_DUMP, rand_value());
    repeat (4) begin
      send_req($urandom_range(0, 1) ? dq_pkg::DQ_POP_BACK : dq_pkg::DQ_POP_FRONT,
               rand_value());
    end
    wait_drained();
  endtask

  task automatic test_random_mix();
    int unsigned             push_pct;
    int unsigned             sent;
    logic [dq_pkg::OpW-1:0]  op;
    for (int seg = 0; seg < 6; seg++) begin
      push_pct    = (seg % 3 == 0) ? 70 : (seg % 3 == 1) ? 30 : 50;
      src_idle_on = (seg != 2);
      snk_idle_on = (seg != 2) && (seg != 4);
      sent = 0;
      while (sent < 16) begin
        op = rand_op(push_pct);
        send_req(op, rand_value());
        if (op != OpRsvdLo && op != OpRsvdHi) sent++;
      end
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  initial begin
    int unsigned hold;
    int unsigned gap_left;
    hold     = 0;
    gap_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_len > 0) begin
        hold        = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else if (!snk_idle_on) begin
        out_ready_i = 1'b1;
      end else if (gap_left > 0) begin
        out_ready_i = 1'b0;
        gap_left--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 4) == 0) gap_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin : check_rsp
    dq_pkg::dq_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result value", out_rsp_o.out_value, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.out_value !== want.out_value)
          report_mismatch("out_value", out_rsp_o.out_value, want.out_value);
        if (out_rsp_o.status !== want.status)
          report_mismatch("status", 32'(out_rsp_o.status), 32'(want.status));
        if (out_rsp_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_rsp_o.entry_count), 32'(want.entry_count));
        if (out_rsp_o.last_result !== want.last_result)
          report_mismatch("last_result", 32'(out_rsp_o.last_result), 32'(want.last_result));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_edges();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (FlushWait) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
